### rtl/utim_pkg.sv
package utim_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CMD_WIDTH   = 3;
  localparam int unsigned PCT_WIDTH   = 7;
  localparam int unsigned CFG_ADDR_W  = 3;

  // duty math: percent * (reload + 1), then divide by 100 through a reciprocal
  localparam int unsigned PROD_W    = COUNT_WIDTH + 1 + PCT_WIDTH;
  localparam int unsigned DIV_SHIFT = PROD_W + PCT_WIDTH;
  localparam longint unsigned DIV_MUL_L = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;
  localparam int unsigned DIV_MUL_W = DIV_SHIFT - PCT_WIDTH + 2;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_L[DIV_MUL_W-1:0];
  localparam logic [PCT_WIDTH-1:0] PCT_MAX = PCT_WIDTH'(100);

  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned RES_W       = 3 + 2 * COUNT_WIDTH;
  localparam int unsigned TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

  // commands
  localparam logic [CMD_WIDTH-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_WR_CMP    = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_WR_DUTY   = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_CLR_FLAG  = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_FORCE_UPD = 3'd4;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PRESCALER  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AUTORELOAD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PRELOAD_EN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IRQ_EN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CH_EN      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CNT_EN     = 3'd6;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] prescaler;
    logic [COUNT_WIDTH-1:0] auto_reload;
    logic                   preload_en;
    logic                   irq_en;
    logic                   invert;
    logic                   ch_en;
    logic                   cnt_en;
  } cfg_t;

  typedef struct packed {
    logic [CMD_WIDTH-1:0]   cmd;
    logic [TDATA_IN_W-1:0]  value;
    logic [COUNT_WIDTH-1:0] duty_cmp;
  } item_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] active_compare;
    logic [COUNT_WIDTH-1:0] count;
    logic                   irq;
    logic                   update_flag;
    logic                   pwm_out;
  } res_t;

endpackage

### rtl/utim_duty.sv
module utim_duty (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  utim_pkg::cfg_t        cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [utim_pkg::CMD_WIDTH-1:0]  cmd_i,
  input  logic [utim_pkg::TDATA_IN_W-1:0] value_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output utim_pkg::item_t       item_o
);
  import utim_pkg::*;

  localparam int unsigned QPROD_W = PROD_W + DIV_MUL_W;

  // stage 1: clamp percent and multiply by period length
  logic                   v1_q;
  logic [CMD_WIDTH-1:0]   cmd1_q;
  logic [TDATA_IN_W-1:0]  val1_q;
  logic [PROD_W-1:0]      prod1_q, prod1_d;
  logic [PCT_WIDTH-1:0]   pct;
  logic [COUNT_WIDTH:0]   period;

  // stage 2: divide by 100
  logic                   v2_q;
  item_t                  item2_q, item2_d;
  logic [QPROD_W-1:0]     qprod;
  logic [QPROD_W-DIV_SHIFT-1:0] quot;

  logic en1, en2;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    pct = (value_i > TDATA_IN_W'(PCT_MAX)) ? PCT_MAX : value_i[PCT_WIDTH-1:0];
    period  = {1'b0, cfg_i.auto_reload} + (COUNT_WIDTH+1)'(1);
    prod1_d = PROD_W'(pct) * PROD_W'(period);
  end

  always_comb begin
    qprod = QPROD_W'(prod1_q) * QPROD_W'(DIV_MUL);
    quot  = qprod[QPROD_W-1:DIV_SHIFT];
    item2_d.cmd   = cmd1_q;
    item2_d.value = val1_q;
    // saturate at the counter maximum
    if (quot > (QPROD_W-DIV_SHIFT)'({COUNT_WIDTH{1'b1}})) begin
      item2_d.duty_cmp = {COUNT_WIDTH{1'b1}};
    end else begin
      item2_d.duty_cmp = quot[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      cmd1_q  <= cmd_i;
      val1_q  <= value_i;
      prod1_q <= prod1_d;
    end
    if (en2 && v1_q) begin
      item2_q <= item2_d;
    end
  end

  assign valid_o = v2_q;
  assign item_o  = item2_q;

endmodule

### rtl/utim_core.sv
module utim_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  utim_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  utim_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output utim_pkg::res_t  res_o
);
  import utim_pkg::*;

  logic [COUNT_WIDTH-1:0] psc_q, psc_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] shadow_q, shadow_d;
  logic [COUNT_WIDTH-1:0] live_q, live_d;
  logic                   flag_q, flag_d;
  logic                   ov_q;
  res_t                   res_q, res_d;
  logic                   upd;
  logic                   set_cmp;
  logic [COUNT_WIDTH-1:0] new_cmp;
  logic                   take;
  logic                   level;

  assign ready_o = !ov_q || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    psc_d    = psc_q;
    cnt_d    = cnt_q;
    shadow_d = shadow_q;
    live_d   = live_q;
    flag_d   = flag_q;
    upd      = 1'b0;
    set_cmp  = 1'b0;
    new_cmp  = item_i.value[COUNT_WIDTH-1:0];

    case (item_i.cmd)
      CMD_TICK: begin
        if (cfg_i.cnt_en) begin
          if (psc_q >= cfg_i.prescaler) begin
            psc_d = '0;
            if (cnt_q >= cfg_i.auto_reload) begin
              upd = 1'b1;
            end else begin
              cnt_d = cnt_q + COUNT_WIDTH'(1);
            end
          end else begin
            psc_d = psc_q + COUNT_WIDTH'(1);
          end
        end
      end
      CMD_WR_CMP: begin
        set_cmp = 1'b1;
      end
      CMD_WR_DUTY: begin
        set_cmp = 1'b1;
        new_cmp = item_i.duty_cmp;
      end
      CMD_CLR_FLAG: begin
        flag_d = 1'b0;
      end
      CMD_FORCE_UPD: begin
        psc_d = '0;
        upd   = 1'b1;
      end
      default: begin
      end
    endcase

    if (set_cmp) begin
      shadow_d = new_cmp;
      if (!cfg_i.preload_en) live_d = new_cmp;
    end
    if (upd) begin
      cnt_d  = '0;
      flag_d = 1'b1;
      if (cfg_i.preload_en) live_d = shadow_q;
    end

    level = ((cnt_d < live_d) ^ cfg_i.invert) & cfg_i.ch_en;
    res_d.pwm_out        = level;
    res_d.update_flag    = flag_d;
    res_d.irq            = flag_d & cfg_i.irq_en;
    res_d.count          = cnt_d;
    res_d.active_compare = live_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psc_q    <= '0;
      cnt_q    <= '0;
      shadow_q <= '0;
      live_q   <= '0;
      flag_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (ready_o) ov_q <= valid_i;
      if (take) begin
        psc_q    <= psc_d;
        cnt_q    <= cnt_d;
        shadow_q <= shadow_d;
        live_q   <= live_d;
        flag_q   <= flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign valid_o = ov_q;
  assign res_o   = res_q;

endmodule

### rtl/up_counting_pwm_timer.sv
// Channel  Dir  Handshake         Payload
// s_*      in   s_tvalid/s_tready tuser = cmd, tdata = value
// m_*      out  m_tvalid/m_tready tdata = pwm_out, update_flag, irq, count, active_compare
// cfg_*    in   cfg_valid/cfg_ready  cfg_addr = register index, cfg_data = value
//
// One item per cycle unless m_tready stalls; results pass both duty stages, then res_q.
// Duty multiply and divide-by-100 reciprocal each own a pipeline stage; the
// counter/flag/compare update runs in the last stage in front of the output register.
// Reset clears all counters, compares and the flag; reload resets to all ones.
// A stalled output backs up the stages in order; cfg writes are always taken.
module up_counting_pwm_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] value
  input  logic [2:0]  s_tuser,  // [2:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [0] pwm_out, [1] update_flag, [2] irq,
                                // [18:3] count, [34:19] active_compare, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import utim_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  logic  mid_valid, mid_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescaler   <= '0;
      cfg_q.auto_reload <= '1;
      cfg_q.preload_en  <= 1'b0;
      cfg_q.irq_en      <= 1'b0;
      cfg_q.invert      <= 1'b0;
      cfg_q.ch_en       <= 1'b0;
      cfg_q.cnt_en      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_PRESCALER:  cfg_q.prescaler   <= cfg_data[COUNT_WIDTH-1:0];
        REG_AUTORELOAD: cfg_q.auto_reload <= cfg_data[COUNT_WIDTH-1:0];
        REG_PRELOAD_EN: cfg_q.preload_en  <= cfg_data[0];
        REG_IRQ_EN:     cfg_q.irq_en      <= cfg_data[0];
        REG_INVERT:     cfg_q.invert      <= cfg_data[0];
        REG_CH_EN:      cfg_q.ch_en       <= cfg_data[0];
        REG_CNT_EN:     cfg_q.cnt_en      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  utim_duty u_duty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_tvalid),
    .ready_o (s_tready),
    .cmd_i   (s_tuser),
    .value_i (s_tdata),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .item_o  (item)
  );

  utim_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .item_i  (item),
    .valid_o (m_tvalid),
    .ready_i (m_tready),
    .res_o   (res)
  );

  assign m_tdata = {(TDATA_OUT_W - RES_W)'(0), res};

endmodule
